/* design/edtt_pkg.sv */
package edtt_pkg;

  localparam int NODE_BITS   = 16;
  localparam int TOP_K       = 10;
  localparam int DEGREE_BITS = 32;

  localparam int NODE_COUNT = 1 << NODE_BITS;
  localparam int SLOT_BITS  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic        action;
    logic [15:0] from_node;
    logic [15:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] entry_node;
    logic [31:0] entry_degree;
    logic [31:0] source_degree;
    logic [31:0] target_degree;
    logic [31:0] edges_seen;
    logic [16:0] nodes_seen;
    logic        last;
  } out_item_t;

  // Head of the request queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  // Control from the back end to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT_ADD,
    ST_SORT,
    ST_LIST
  } back_state_t;

endpackage

/* design/edtt_ram.sv */
module edtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/edtt_front.sv */
module edtt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  edtt_pkg::in_item_t   in_data,
  input  edtt_pkg::back_ctrl_t ctrl,
  output edtt_pkg::queue_head_t head
);

  localparam int PTR_BITS = $clog2(edtt_pkg::QUEUE_DEPTH);

  edtt_pkg::in_item_t    slots [edtt_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [PTR_BITS:0]     count;
  logic                  push;
  logic                  pop;

  assign in_stall = ctrl.clearing || (count == (PTR_BITS + 1)'(edtt_pkg::QUEUE_DEPTH));
  assign push = in_valid && !in_stall;
  assign pop  = ctrl.pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(edtt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(edtt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

/* design/edtt_back.sv */
module edtt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  edtt_pkg::queue_head_t head,
  output edtt_pkg::back_ctrl_t  ctrl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output edtt_pkg::out_item_t   out_data
);

  localparam int NB = edtt_pkg::NODE_BITS;
  localparam int DB = edtt_pkg::DEGREE_BITS;
  localparam int SB = edtt_pkg::SLOT_BITS;
  localparam logic [SB-1:0] SLOT_LAST = SB'(edtt_pkg::TOP_K - 1);
  localparam logic [SB-1:0] SORT_I_LAST = SB'((edtt_pkg::TOP_K > 1) ? edtt_pkg::TOP_K - 2 : 0);

  edtt_pkg::back_state_t state, state_next;

  logic [NB-1:0] clr_addr;
  logic [NB-1:0] node_cur;
  logic [NB-1:0] node_tgt;
  logic          phase;
  logic [DB-1:0] deg_cur;
  logic [DB-1:0] src_deg;
  logic [DB-1:0] tgt_deg;
  logic [SB-1:0] scan_idx;
  logic          hit;
  logic [SB-1:0] hit_idx;
  logic [SB-1:0] low_idx;
  logic [SB-1:0] si;
  logic [SB-1:0] sj;
  logic [31:0]   edge_total;
  logic [16:0]   node_total;
  logic [NB-1:0] top_ids [edtt_pkg::TOP_K];
  logic [DB-1:0] top_deg [edtt_pkg::TOP_K];

  logic          ram_we;
  logic [NB-1:0] ram_waddr;
  logic [DB-1:0] ram_wdata;
  logic          ram_re;
  logic [DB-1:0] ram_rdata;
  logic [DB-1:0] deg_new;
  logic          can_load;
  logic          load;
  logic [SB-1:0] idx_plus;
  logic          list_last;

  edtt_ram #(
    .WIDTH(DB),
    .DEPTH(edtt_pkg::NODE_COUNT)
  ) u_degree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (node_cur),
    .rdata (ram_rdata)
  );

  assign can_load = !out_valid || !out_stall;
  assign load     = can_load &&
                    (state == edtt_pkg::ST_EMIT_ADD || state == edtt_pkg::ST_LIST);
  assign deg_new  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign idx_plus = (scan_idx == SLOT_LAST) ? scan_idx : scan_idx + 1'b1;
  assign list_last = (scan_idx == SLOT_LAST) || (top_deg[idx_plus] == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      edtt_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = edtt_pkg::ST_IDLE;
      end
      edtt_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (head.item.action == edtt_pkg::ACT_ADD) begin
            state_next = edtt_pkg::ST_READ;
          end else if (edtt_pkg::TOP_K > 1) begin
            state_next = edtt_pkg::ST_SORT;
          end else begin
            state_next = edtt_pkg::ST_LIST;
          end
        end
      end
      edtt_pkg::ST_READ:   state_next = edtt_pkg::ST_UPDATE;
      edtt_pkg::ST_UPDATE: state_next = edtt_pkg::ST_SCAN;
      edtt_pkg::ST_SCAN: begin
        if (scan_idx == SLOT_LAST) state_next = edtt_pkg::ST_APPLY;
      end
      edtt_pkg::ST_APPLY: begin
        state_next = phase ? edtt_pkg::ST_EMIT_ADD : edtt_pkg::ST_READ;
      end
      edtt_pkg::ST_EMIT_ADD: begin
        if (can_load) state_next = edtt_pkg::ST_IDLE;
      end
      edtt_pkg::ST_SORT: begin
        if (sj == SLOT_LAST && si == SORT_I_LAST) state_next = edtt_pkg::ST_LIST;
      end
      edtt_pkg::ST_LIST: begin
        if (can_load && (top_deg[0] == '0 || list_last)) state_next = edtt_pkg::ST_IDLE;
      end
      default: state_next = edtt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = node_cur;
    ram_wdata     = deg_new;
    ram_re        = 1'b0;
    ctrl.pop      = 1'b0;
    ctrl.clearing = 1'b0;
    unique case (state)
      edtt_pkg::ST_CLEAR: begin
        ctrl.clearing = 1'b1;
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
      end
      edtt_pkg::ST_IDLE:   ctrl.pop = head.valid;
      edtt_pkg::ST_READ:   ram_re = 1'b1;
      edtt_pkg::ST_UPDATE: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= edtt_pkg::ST_CLEAR;
      clr_addr   <= '0;
      edge_total <= '0;
      node_total <= '0;
      out_valid  <= 1'b0;
      for (int k = 0; k < edtt_pkg::TOP_K; k++) begin
        top_ids[k] <= '0;
        top_deg[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        edtt_pkg::ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        edtt_pkg::ST_IDLE: begin
          if (head.valid && head.item.action == edtt_pkg::ACT_ADD) begin
            if (edge_total != '1) edge_total <= edge_total + 1'b1;
          end
        end
        edtt_pkg::ST_UPDATE: begin
          if (ram_rdata == '0 && node_total != '1) node_total <= node_total + 1'b1;
        end
        edtt_pkg::ST_APPLY: begin
          if (hit) begin
            top_deg[hit_idx] <= deg_cur;
          end else if (deg_cur > top_deg[low_idx]) begin
            top_ids[low_idx] <= node_cur;
            top_deg[low_idx] <= deg_cur;
          end
        end
        edtt_pkg::ST_SORT: begin
          if (top_deg[si] < top_deg[sj]) begin
            top_ids[si] <= top_ids[sj];
            top_deg[si] <= top_deg[sj];
            top_ids[sj] <= top_ids[si];
            top_deg[sj] <= top_deg[si];
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state)
      edtt_pkg::ST_IDLE: begin
        phase    <= 1'b0;
        node_cur <= head.item.from_node[NB-1:0];
        node_tgt <= head.item.to_node[NB-1:0];
        si       <= '0;
        sj       <= SB'(1);
        scan_idx <= '0;
      end
      edtt_pkg::ST_UPDATE: begin
        deg_cur  <= deg_new;
        scan_idx <= '0;
        hit      <= 1'b0;
        hit_idx  <= '0;
        low_idx  <= '0;
      end
      edtt_pkg::ST_SCAN: begin
        if (!hit && top_ids[scan_idx] == node_cur) begin
          hit     <= 1'b1;
          hit_idx <= scan_idx;
        end
        if (top_deg[scan_idx] < top_deg[low_idx]) low_idx <= scan_idx;
        scan_idx <= scan_idx + 1'b1;
      end
      edtt_pkg::ST_APPLY: begin
        if (!phase) begin
          src_deg  <= deg_cur;
          node_cur <= node_tgt;
          phase    <= 1'b1;
        end else begin
          tgt_deg <= deg_cur;
        end
      end
      edtt_pkg::ST_EMIT_ADD: begin
        if (can_load) begin
          out_data.kind          <= edtt_pkg::KIND_ACK;
          out_data.entry_node    <= '0;
          out_data.entry_degree  <= '0;
          out_data.source_degree <= 32'(src_deg);
          out_data.target_degree <= 32'(tgt_deg);
          out_data.edges_seen    <= edge_total;
          out_data.nodes_seen    <= node_total;
          out_data.last          <= 1'b1;
        end
      end
      edtt_pkg::ST_SORT: begin
        if (sj == SLOT_LAST) begin
          si <= si + 1'b1;
          sj <= si + SB'(2);
        end else begin
          sj <= sj + 1'b1;
        end
        scan_idx <= '0;
      end
      edtt_pkg::ST_LIST: begin
        if (can_load) begin
          out_data.source_degree <= '0;
          out_data.target_degree <= '0;
          out_data.edges_seen    <= edge_total;
          out_data.nodes_seen    <= node_total;
          if (top_deg[0] == '0) begin
            out_data.kind         <= edtt_pkg::KIND_EMPTY;
            out_data.entry_node   <= '0;
            out_data.entry_degree <= '0;
            out_data.last         <= 1'b1;
          end else begin
            out_data.kind         <= edtt_pkg::KIND_ENTRY;
            out_data.entry_node   <= 16'(top_ids[scan_idx]);
            out_data.entry_degree <= 32'(top_deg[scan_idx]);
            out_data.last         <= list_last;
          end
          scan_idx <= idx_plus;
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/edge_degree_topk_tracker_unit.sv */
// An add request takes one dispatch step, then per node one degree memory read, one write,
// a scan of all TOP_K slots and one slot update. A readout takes one dispatch step and a
// compare-exchange of every pair of slots, TOP_K*(TOP_K-1)/2 pairs (45), then one result
// per cycle while out_stall is low. Results leave through an output register; a two-entry
// queue takes requests meanwhile. After reset the degree memory is cleared one entry a cycle
// over all 2^NODE_BITS entries (65536), during which in_stall is held high.
module edge_degree_topk_tracker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  edtt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output edtt_pkg::out_item_t out_data
);

  edtt_pkg::queue_head_t head;
  edtt_pkg::back_ctrl_t  ctrl;

  edtt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .ctrl     (ctrl),
    .head     (head)
  );

  edtt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/edtt_checker.sv */
module edtt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input edtt_pkg::out_item_t out_data
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.kind == edtt_pkg::KIND_ACK || out_data.kind == edtt_pkg::KIND_ENTRY
                   || out_data.kind == edtt_pkg::KIND_EMPTY))
    else $error("illegal result kind");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != edtt_pkg::KIND_ENTRY |-> out_data.last)
    else $error("single result without last");

  a_entry_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == edtt_pkg::KIND_ENTRY |-> out_data.entry_degree != '0)
    else $error("list entry with zero degree");

endmodule

bind edge_degree_topk_tracker_unit edtt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
